>>> hdl/mesh_unit_box_normalizer_defines.svh
// Assertion macros for the RTL that carries checks.
// Each check is sampled on the rising edge of clock.
`ifndef MESH_UNIT_BOX_NORMALIZER_DEFINES_SVH
`define MESH_UNIT_BOX_NORMALIZER_DEFINES_SVH

`ifndef ASSERT_OFF
// Check that is switched off while reset is high.
`define MUBN_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Check that also holds while reset is high.
`define MUBN_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);
`else
`define MUBN_ASSERT(name, prop, msg)
`define MUBN_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

>>> hdl/mubn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mubn_pkg;

   localparam int MAX_VERTICES = 1024;
   localparam int ADDR_W       = $clog2(MAX_VERTICES);
   localparam int COUNT_W      = $clog2(MAX_VERTICES + 1);

   localparam int ACTION_W = 2;
   localparam int COORD_W  = 32;
   localparam int INDEX_W  = 10;
   localparam int STATUS_W = 2;
   localparam int FIT_W    = 16;

   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 96;
   localparam int VTX_W      = 3 * COORD_W;

   // Scale is fit_size * 2^41 / extent.
   localparam int FIT_SHIFT = 41;
   localparam int QUOT_W    = FIT_W + FIT_SHIFT;
   localparam int QCNT_W    = $clog2(QUOT_W);
   localparam int EXT_W     = COORD_W;

   // The magnitude of an offset from the centre reaches 2^31.
   localparam int MAG_W  = COORD_W + 1;
   localparam int PART_W = (QUOT_W + 1) / 2;
   localparam int PROD_W = MAG_W + PART_W;
   localparam int ACC_W  = MAG_W + 2 * PART_W - 1;

   localparam logic [FIT_W-1:0] FIT_RESET = 16'd256;

   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_DEGEN    = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_UNLOADED = 2'd2;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      logic mul_en;     // register the product of the current operands
      logic acc_load;   // accumulator takes the low partial product
      logic acc_add_hi; // accumulator adds the high partial product
   } mac_ctrl_type;

endpackage
`default_nettype wire

>>> hdl/mubn_div.sv
`timescale 1ns / 1ps
`default_nettype none
module mubn_div (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  wire [mubn_pkg::FIT_W-1:0]   fit_size,
   input  wire [mubn_pkg::EXT_W-1:0]   divisor,
   output logic                         done,
   output logic [mubn_pkg::QUOT_W-1:0] quotient
);
   import mubn_pkg::*;

   logic [QUOT_W-1:0] num_ff;
   logic [QUOT_W-1:0] quot_ff;
   logic [EXT_W-1:0]  rem_ff;
   logic [EXT_W-1:0]  dvs_ff;
   logic [QCNT_W-1:0] cnt_ff;
   logic              run_ff;
   logic              done_ff;

   logic [EXT_W:0]    trial_in;
   logic [EXT_W:0]    diff_in;
   logic              fits_in;

   // Restoring division, one quotient bit per cycle, most significant first.
   always_comb begin
      trial_in = {rem_ff, num_ff[QUOT_W-1]};
      diff_in  = trial_in - {1'b0, dvs_ff};
      fits_in  = trial_in >= {1'b0, dvs_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= QCNT_W'(QUOT_W - 1);
         end else if (run_ff) begin
            if (cnt_ff == '0) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff  <= {fit_size, {FIT_SHIFT{1'b0}}};
         rem_ff  <= '0;
         quot_ff <= '0;
         dvs_ff  <= divisor;
      end else if (run_ff) begin
         num_ff  <= {num_ff[QUOT_W-2:0], 1'b0};
         rem_ff  <= fits_in ? diff_in[EXT_W-1:0] : trial_in[EXT_W-1:0];
         quot_ff <= {quot_ff[QUOT_W-2:0], fits_in};
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule
`default_nettype wire

>>> hdl/mubn_mac.sv
`timescale 1ns / 1ps
`default_nettype none
module mubn_mac (
   input  wire                         clock,
   input  wire [mubn_pkg::MAG_W-1:0]  mag,
   input  wire [mubn_pkg::PART_W-1:0] part,
   input  wire mubn_pkg::mac_ctrl_type ctrl,
   output logic [mubn_pkg::ACC_W-1:0] acc
);
   import mubn_pkg::*;

   logic [PROD_W-1:0] prod_ff;
   logic [ACC_W-1:0]  acc_ff;

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= mag * part;
      end
      if (ctrl.acc_load) begin
         acc_ff <= ACC_W'(prod_ff);
      end else if (ctrl.acc_add_hi) begin
         acc_ff <= acc_ff + (ACC_W'(prod_ff) << PART_W);
      end
   end

   assign acc = acc_ff;

endmodule
`default_nettype wire

>>> hdl/mesh_unit_box_normalizer.sv
`timescale 1ns / 1ps
`default_nettype none
`include "mesh_unit_box_normalizer_defines.svh"
// Vertex store with bounding box normalisation. A clear or a load gives no response. A read
// of an index that has not been loaded goes straight to the last step and presents its
// response (status 2) once the response register is loaded; a read of a box of zero extent
// first passes through fetch and set-up. Any other read goes through fetch, set-up, the
// bit-serial divider that forms the scale (57 quotient bits, one a cycle, then a flag for
// completion), the three coordinates in turn in the shared multiply-accumulate unit (two
// partial products each), and the load of the response register. Only one request is
// worked on at a time; req_tready is high only while the block waits for a request. The
// response register lets the next request be taken while a response is still waiting; a
// read that finishes while that register is still full waits in its last step until the
// response is taken. The store needs no clearing pass after reset, as only loaded entries
// are ever read.
module mesh_unit_box_normalizer (
   input  wire                              clock,
   input  wire                              reset,
   // csr_data: fit_size (unsigned Q8.8)
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire [mubn_pkg::FIT_W-1:0]       csr_data,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   // req_tdata: coord_x [31:0], coord_y [63:32], coord_z [95:64], vertex_index [105:96]
   input  wire [mubn_pkg::REQ_DATA_W-1:0]  req_tdata,
   // req_tuser: action [1:0]
   input  wire [mubn_pkg::ACTION_W-1:0]    req_tuser,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // rsp_tdata: norm_x [31:0], norm_y [63:32], norm_z [95:64]
   output logic [mubn_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // rsp_tuser: status [1:0]
   output logic [mubn_pkg::STATUS_W-1:0]   rsp_tuser
);
   import mubn_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_FETCH = 3'd1;
   localparam logic [2:0] S_PREP  = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_MUL   = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]          state_ff;
   logic [2:0]          state_in;
   logic [FIT_W-1:0]    fit_ff;
   logic [COUNT_W-1:0]  count_ff;
   coord_type           low_ff [3];
   coord_type           high_ff [3];
   logic [EXT_W-1:0]    ext_ff;
   logic [MAG_W-1:0]    mag_ff [3];
   logic [2:0]          neg_ff;
   logic [1:0]          axis_ff;
   logic [1:0]          step_ff;
   coord_type           res_ff [3];
   logic [STATUS_W-1:0] res_stat_ff;

   logic                   rsp_valid_ff;
   logic [RSP_DATA_W-1:0]  rsp_data_ff;
   logic [STATUS_W-1:0]    rsp_user_ff;

   logic [VTX_W-1:0]    vertex_mem [MAX_VERTICES];
   logic [VTX_W-1:0]    vtx_q_ff;

   coord_type           req_coord [3];
   logic [INDEX_W-1:0]  req_index;
   logic                req_fire;
   logic                store_full;
   logic                index_loaded;

   logic [EXT_W-1:0]    extent_in [3];
   logic [EXT_W-1:0]    ext_in;
   logic [MAG_W-1:0]    mag_in [3];
   logic [2:0]          neg_in;

   logic                div_start;
   logic                div_done;
   logic [QUOT_W-1:0]   scale;
   logic [2*PART_W-1:0] scale_wide;
   logic [PART_W-1:0]   mac_part;
   mac_ctrl_type        mac_ctrl;
   logic [ACC_W-1:0]    mac_acc;

   logic [ACC_W-COORD_W-1:0] sat_mag_in;
   logic [ACC_W-COORD_W-1:0] sat_lim_in;
   coord_type                sat_out_in;
   logic                     rsp_free;

   assign req_coord[0] = req_tdata[COORD_W-1:0];
   assign req_coord[1] = req_tdata[2*COORD_W-1:COORD_W];
   assign req_coord[2] = req_tdata[3*COORD_W-1:2*COORD_W];
   assign req_index    = req_tdata[3*COORD_W+INDEX_W-1:3*COORD_W];

   assign csr_ready    = 1'b1;
   assign req_tready   = (state_ff == S_IDLE);
   assign req_fire     = req_tvalid && req_tready;
   assign store_full   = (count_ff >= COUNT_W'(MAX_VERTICES));
   assign index_loaded = (COUNT_W'(req_index) < count_ff);
   assign rsp_free     = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_ff <= FIT_RESET;
      end else if (csr_valid && csr_ready) begin
         fit_ff <= csr_data;
      end
   end

   // Box and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int a = 0; a < 3; a++) begin
            low_ff[a]  <= {1'b0, {(COORD_W-1){1'b1}}};
            high_ff[a] <= {1'b1, {(COORD_W-1){1'b0}}};
         end
      end else if (req_fire) begin
         if (req_tuser == ACT_CLEAR) begin
            count_ff <= '0;
            for (int a = 0; a < 3; a++) begin
               low_ff[a]  <= {1'b0, {(COORD_W-1){1'b1}}};
               high_ff[a] <= {1'b1, {(COORD_W-1){1'b0}}};
            end
         end else if (req_tuser == ACT_LOAD && !store_full) begin
            count_ff <= count_ff + 1'b1;
            for (int a = 0; a < 3; a++) begin
               if (req_coord[a] < low_ff[a]) begin
                  low_ff[a] <= req_coord[a];
               end
               if (req_coord[a] > high_ff[a]) begin
                  high_ff[a] <= req_coord[a];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_tuser == ACT_LOAD && !store_full) begin
         vertex_mem[count_ff[ADDR_W-1:0]] <= req_tdata[VTX_W-1:0];
      end
      if (req_fire && req_tuser == ACT_READ) begin
         vtx_q_ff <= vertex_mem[req_index[ADDR_W-1:0]];
      end
   end

   // Largest extent, and each offset from the box centre as sign and magnitude.
   always_comb begin
      logic signed [COORD_W:0]   sum;
      logic signed [COORD_W:0]   centre;
      logic signed [COORD_W+1:0] diff;
      coord_type                 v;
      for (int a = 0; a < 3; a++) begin
         extent_in[a] = EXT_W'(high_ff[a] - low_ff[a]);
         sum          = {low_ff[a][COORD_W-1], low_ff[a]} + {high_ff[a][COORD_W-1], high_ff[a]};
         centre       = sum >>> 1;
         v            = vtx_q_ff[a*COORD_W +: COORD_W];
         diff         = {{2{v[COORD_W-1]}}, v} - {centre[COORD_W], centre};
         neg_in[a]    = diff[COORD_W+1];
         mag_in[a]    = neg_in[a] ? MAG_W'(-diff) : MAG_W'(diff);
      end
      ext_in = extent_in[0];
      if (extent_in[1] > ext_in) begin
         ext_in = extent_in[1];
      end
      if (extent_in[2] > ext_in) begin
         ext_in = extent_in[2];
      end
   end

   assign div_start = (state_ff == S_PREP) && (ext_ff != '0);

   mubn_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .fit_size (fit_ff),
      .divisor  (ext_ff),
      .done     (div_done),
      .quotient (scale)
   );

   // Each coordinate takes four steps: low product, high product, accumulate, saturate.
   assign scale_wide = (2*PART_W)'(scale);
   assign mac_part   = (step_ff == 2'd0) ? scale_wide[PART_W-1:0]
                                         : scale_wide[2*PART_W-1:PART_W];

   always_comb begin
      mac_ctrl            = '0;
      mac_ctrl.mul_en     = (state_ff == S_MUL) && (step_ff == 2'd0 || step_ff == 2'd1);
      mac_ctrl.acc_load   = (state_ff == S_MUL) && (step_ff == 2'd1);
      mac_ctrl.acc_add_hi = (state_ff == S_MUL) && (step_ff == 2'd2);
   end

   mubn_mac u_mac (
      .clock (clock),
      .mag   (mag_ff[axis_ff]),
      .part  (mac_part),
      .ctrl  (mac_ctrl),
      .acc   (mac_acc)
   );

   // Drop the 32 fraction bits of the scale and clip to the signed range.
   always_comb begin
      sat_mag_in = mac_acc[ACC_W-1:COORD_W];
      sat_lim_in = neg_ff[axis_ff] ? (ACC_W-COORD_W)'(64'h8000_0000)
                                   : (ACC_W-COORD_W)'(64'h7FFF_FFFF);
      if (sat_mag_in > sat_lim_in) begin
         sat_mag_in = sat_lim_in;
      end
      sat_out_in = neg_ff[axis_ff] ? -sat_mag_in[COORD_W-1:0] : sat_mag_in[COORD_W-1:0];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && req_tuser == ACT_READ) begin
               state_in = index_loaded ? S_FETCH : S_DONE;
            end
         end
         S_FETCH: state_in = S_PREP;
         S_PREP:  state_in = (ext_ff == '0) ? S_DONE : S_DIV;
         S_DIV: begin
            if (div_done) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (step_ff == 2'd3 && axis_ff == 2'd2) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         axis_ff  <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_MUL) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == 2'd3) begin
               axis_ff <= axis_ff + 1'b1;
            end
         end else begin
            axis_ff <= '0;
            step_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_fire && req_tuser == ACT_READ && !index_loaded) begin
         for (int a = 0; a < 3; a++) begin
            res_ff[a] <= '0;
         end
         res_stat_ff <= STAT_UNLOADED;
      end
      if (state_ff == S_FETCH) begin
         ext_ff <= ext_in;
      end
      if (state_ff == S_PREP) begin
         for (int a = 0; a < 3; a++) begin
            mag_ff[a] <= mag_in[a];
            res_ff[a] <= '0;
         end
         neg_ff      <= neg_in;
         res_stat_ff <= (ext_ff == '0) ? STAT_DEGEN : STAT_OK;
      end
      if (state_ff == S_MUL && step_ff == 2'd3) begin
         res_ff[axis_ff] <= sat_out_in;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_DONE && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_DONE && rsp_free) begin
         rsp_data_ff <= {res_ff[2], res_ff[1], res_ff[0]};
         rsp_user_ff <= res_stat_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `MUBN_ASSERT(a_count_range, count_ff <= COUNT_W'(MAX_VERTICES), "fill count beyond store depth")
   `MUBN_ASSERT(a_box_order, (count_ff != '0) |-> (low_ff[0] <= high_ff[0] && low_ff[1] <= high_ff[1] && low_ff[2] <= high_ff[2]), "box low above box high")
   `MUBN_ASSERT(a_load_count, (req_fire && req_tuser == ACT_LOAD && !store_full) |=> (count_ff == $past(count_ff) + 1'b1), "load did not advance fill count")
   `MUBN_ASSERT(a_fault_zero, (rsp_tvalid && rsp_tuser != STAT_OK) |-> (rsp_tdata == '0), "error response with non-zero coordinates")

endmodule
`default_nettype wire

>>> sim/mubn_checker.sv
`timescale 1ns / 1ps
module mubn_checker
   import mubn_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   csr_valid,
   input  wire                   csr_ready,
   input  wire [FIT_W-1:0]       csr_data,
   input  wire                   req_tvalid,
   input  wire                   req_tready,
   // req_tdata: coord_x [31:0], coord_y [63:32], coord_z [95:64], vertex_index [105:96]
   input  wire [REQ_DATA_W-1:0]  req_tdata,
   // req_tuser: action [1:0]
   input  wire [ACTION_W-1:0]    req_tuser,
   input  wire                   rsp_tvalid,
   input  wire                   rsp_tready,
   // rsp_tdata: norm_x [31:0], norm_y [63:32], norm_z [95:64]
   input  wire [RSP_DATA_W-1:0]  rsp_tdata,
   // rsp_tuser: status [1:0]
   input  wire [STATUS_W-1:0]    rsp_tuser,
   output int                    error_count,
   output int                    pending_count
);

   typedef struct packed {
      logic [2:0][COORD_W-1:0] norm;
      logic [STATUS_W-1:0]     status;
   } norm_result_type;

   logic [FIT_W-1:0] fit_size_q;
   longint           box_min [3];
   longint           box_max [3];
   int unsigned      vertex_count;
   coord_type        vertices [MAX_VERTICES][3];
   norm_result_type  expected_norms [$];

   task automatic reset_box();
      for (int a = 0; a < 3; a++) begin
         box_min[a] = 64'sd2147483647;
         box_max[a] = -64'sd2147483648;
      end
   endtask

   // The product truncates toward zero and saturates to the signed 32-bit range.
   function automatic coord_type scale_offset(input longint offset, input logic [63:0] scale);
      logic [63:0]  mag;
      logic [63:0]  limit;
      logic [63:0]  whole;
      logic [127:0] prod;
      mag   = (offset < 0) ? 64'(-offset) : 64'(offset);
      limit = (offset < 0) ? 64'h8000_0000 : 64'h7FFF_FFFF;
      prod  = {64'd0, mag} * {64'd0, scale};
      whole = prod[95:32];
      if (whole > limit)
         whole = limit;
      if (offset < 0)
         whole = 64'd0 - whole;
      return whole[COORD_W-1:0];
   endfunction

   function automatic norm_result_type predict_read(input int unsigned idx);
      norm_result_type res;
      logic [63:0]     span;
      logic [63:0]     widest;
      logic [63:0]     scale;
      longint          centre;
      longint          offset;
      res = '0;
      if (idx >= vertex_count) begin
         res.status = STAT_UNLOADED;
         return res;
      end
      widest = 64'd0;
      for (int a = 0; a < 3; a++) begin
         span = 64'(box_max[a] - box_min[a]);
         if (span > widest)
            widest = span;
      end
      if (widest == 64'd0) begin
         res.status = STAT_DEGEN;
         return res;
      end
      scale = {7'd0, fit_size_q, 41'd0} / widest;
      for (int a = 0; a < 3; a++) begin
         centre = (box_min[a] + box_max[a]) >>> 1;
         offset = longint'(vertices[idx][a]) - centre;
         res.norm[a] = scale_offset(offset, scale);
      end
      res.status = STAT_OK;
      return res;
   endfunction

   always @(posedge clock) begin : monitor
      norm_result_type exp_norm;
      coord_type       coord;
      int unsigned     idx;
      if (reset) begin
         fit_size_q   = FIT_RESET;
         vertex_count = 0;
         reset_box();
         expected_norms.delete();
         error_count   = 0;
         pending_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_norms.size() == 0) begin
               $display("%0t: response with nothing expected, expected none, actual data %h status %0d",
                        $time, rsp_tdata, rsp_tuser);
               error_count++;
            end else begin
               exp_norm = expected_norms.pop_front();
               for (int a = 0; a < 3; a++) begin
                  if (rsp_tdata[a*COORD_W +: COORD_W] !== exp_norm.norm[a]) begin
                     $display("%0t: norm axis %0d mismatch, expected %h, actual %h", $time, a,
                              exp_norm.norm[a], rsp_tdata[a*COORD_W +: COORD_W]);
                     error_count++;
                  end
               end
               if (rsp_tuser !== exp_norm.status) begin
                  $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                           exp_norm.status, rsp_tuser);
                  error_count++;
               end
            end
         end

         if (csr_valid && csr_ready)
            fit_size_q = csr_data;

         if (req_tvalid && req_tready) begin
            case (req_tuser)
               ACT_CLEAR: begin
                  vertex_count = 0;
                  reset_box();
               end
               ACT_LOAD: begin
                  // A full store ignores further loads and keeps its box.
                  if (vertex_count < MAX_VERTICES) begin
                     for (int a = 0; a < 3; a++) begin
                        coord = req_tdata[a*COORD_W +: COORD_W];
                        vertices[vertex_count][a] = coord;
                        if (longint'(coord) < box_min[a])
                           box_min[a] = longint'(coord);
                        if (longint'(coord) > box_max[a])
                           box_max[a] = longint'(coord);
                     end
                     vertex_count++;
                  end
               end
               ACT_READ: begin
                  idx = req_tdata[3*COORD_W +: INDEX_W];
                  expected_norms = {expected_norms, predict_read(idx)};
               end
               default: ;
            endcase
         end
         pending_count = expected_norms.size();
      end
   end

endmodule

>>> sim/tb_mesh_unit_box_normalizer.sv
`timescale 1ns / 1ps
module tb_mesh_unit_box_normalizer
   import mubn_pkg::*;
;

   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = 100;
   localparam int LONG_HOLD    = 300;
   localparam int STALL_LIMIT  = 3000;

   typedef enum int {SPREAD_FULL, SPREAD_NEAR, SPREAD_TIGHT, SPREAD_FLAT} coord_spread_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [FIT_W-1:0]      csr_data;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [ACTION_W-1:0]   req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;

   int   error_total;
   int   expected_left;
   int   req_idle_pct = 0;
   int   rsp_idle_pct = 0;
   int   hold_left    = 0;
   logic long_hold_req = 1'b0;

   always #2 clock = ~clock;

   mesh_unit_box_normalizer uut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   mubn_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .error_count   (error_total),
      .pending_count (expected_left)
   );

   // Response side: random back-pressure, or a long hold-off when one is requested.
   always @(negedge clock) begin
      if (long_hold_req) begin
         long_hold_req = 1'b0;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb_mesh_unit_box_normalizer: done, errors");
      $finish;
   end

   // Called at a falling edge; returns at the falling edge after the transaction.
   task automatic push_request(input logic [ACTION_W-1:0] act, input logic [31:0] x,
                               input logic [31:0] y, input logic [31:0] z,
                               input logic [INDEX_W-1:0] idx);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {6'd0, idx, z, y, x};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_fit(input logic [FIT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Loads and clears give no response, so a fixed pause follows the last response.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_left != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic logic [31:0] pick_coord(input coord_spread_type spread,
                                              input logic [31:0] base);
      logic [31:0] v;
      case (spread)
         SPREAD_FULL:  v = $urandom;
         SPREAD_NEAR:  v = $urandom_range(2**21) - 2**20;
         SPREAD_TIGHT: v = base + $urandom_range(3);
         default:      v = base;
      endcase
      if ((spread == SPREAD_FULL || spread == SPREAD_NEAR) && $urandom_range(15) == 0)
         v = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      return v;
   endfunction

   // One mesh: a clear, a run of loads with the odd stray transaction, then reads.
   task automatic run_session();
      coord_spread_type   spread;
      logic [31:0]        base;
      logic [INDEX_W-1:0] idx;
      int                 n_load;
      int                 n_read;
      push_request(ACT_CLEAR, $urandom, $urandom, $urandom, INDEX_W'($urandom));
      spread = coord_spread_type'($urandom_range(3));
      base   = $urandom;
      n_load = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      for (int i = 0; i < n_load; i++) begin
         push_request(ACT_LOAD, pick_coord(spread, base), pick_coord(spread, base),
                      pick_coord(spread, base), INDEX_W'($urandom));
         case ($urandom_range(23))
            0: push_request(ACT_UNUSED, $urandom, $urandom, $urandom, INDEX_W'($urandom));
            1: push_request(ACT_READ, $urandom, $urandom, $urandom, INDEX_W'($urandom_range(i)));
            default: ;
         endcase
      end
      n_read = $urandom_range(1, 8);
      for (int i = 0; i < n_read; i++) begin
         case ($urandom_range(7))
            0:       idx = INDEX_W'(n_load);
            1:       idx = INDEX_W'($urandom);
            default: idx = INDEX_W'($urandom_range(n_load - 1));
         endcase
         push_request(ACT_READ, $urandom, $urandom, $urandom, idx);
      end
   endtask

   // Fills the store past its capacity, reading back now and then.
   task automatic fill_store();
      coord_spread_type spread;
      push_request(ACT_CLEAR, $urandom, $urandom, $urandom, INDEX_W'($urandom));
      for (int i = 0; i < MAX_VERTICES + 3; i++) begin
         spread = $urandom_range(1) ? SPREAD_FULL : SPREAD_NEAR;
         push_request(ACT_LOAD, pick_coord(spread, 32'd0), pick_coord(spread, 32'd0),
                      pick_coord(spread, 32'd0), INDEX_W'($urandom));
         if ($urandom_range(24) == 0)
            push_request(ACT_READ, $urandom, $urandom, $urandom,
                         INDEX_W'($urandom_range((i < MAX_VERTICES) ? i : MAX_VERTICES - 1)));
      end
      push_request(ACT_READ, $urandom, $urandom, $urandom, INDEX_W'(MAX_VERTICES - 1));
      push_request(ACT_READ, $urandom, $urandom, $urandom, '0);
      repeat (6)
         push_request(ACT_READ, $urandom, $urandom, $urandom, INDEX_W'($urandom));
   endtask

   initial begin : stimulus
      logic [FIT_W-1:0] fit_plan [6];
      reset      = 1'b1;
      csr_valid  = 1'b0;
      csr_data   = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = ACT_CLEAR;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      req_idle_pct = 24;
      rsp_idle_pct = 46;

      // Directed part, at the reset value of fit_size.
      push_request(ACT_READ, $urandom, $urandom, $urandom, '0);
      push_request(ACT_UNUSED, $urandom, $urandom, $urandom, '1);
      push_request(ACT_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, '1);
      push_request(ACT_READ, 32'h0, 32'h0, 32'h0, '0);
      push_request(ACT_READ, 32'h0, 32'h0, 32'h0, 10'd1);
      push_request(ACT_LOAD, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, '0);
      push_request(ACT_READ, $urandom, $urandom, $urandom, '0);
      push_request(ACT_READ, $urandom, $urandom, $urandom, 10'd1);
      push_request(ACT_READ, $urandom, $urandom, $urandom, 10'd2);
      push_request(ACT_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
      push_request(ACT_READ, $urandom, $urandom, $urandom, '0);
      push_request(ACT_LOAD, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 10'd5);
      push_request(ACT_LOAD, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 10'd9);
      push_request(ACT_LOAD, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001, '0);
      push_request(ACT_READ, $urandom, $urandom, $urandom, '0);
      push_request(ACT_READ, $urandom, $urandom, $urandom, 10'd1);
      push_request(ACT_READ, $urandom, $urandom, $urandom, 10'd2);
      push_request(ACT_CLEAR, $urandom, $urandom, $urandom, '0);
      push_request(ACT_LOAD, 32'h0000_0005, 32'h0000_0005, 32'h0000_0005, '0);
      push_request(ACT_LOAD, 32'h0000_0005, 32'h0000_0005, 32'h0000_0005, '0);
      push_request(ACT_READ, $urandom, $urandom, $urandom, 10'd1);

      fit_plan[0] = 16'hFFFF;
      fit_plan[1] = 16'h0000;
      fit_plan[2] = 16'h0001;
      fit_plan[3] = FIT_W'($urandom);
      fit_plan[4] = FIT_RESET;
      fit_plan[5] = FIT_W'($urandom);

      for (int seg = 0; seg < 6; seg++) begin
         case (seg / 2)
            0: begin
               req_idle_pct = 24;
               rsp_idle_pct = 46;
            end
            1: begin
               req_idle_pct = 46;
               rsp_idle_pct = 24;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         wait_idle();
         write_fit(fit_plan[seg]);
         // The receiver stops for a long while so that the block backs up its input.
         if (seg == 2)
            long_hold_req = 1'b1;
         repeat (4) run_session();
         if (seg == 5)
            fill_store();
      end

      wait_idle();
      if (error_total == 0 && expected_left == 0)
         $display("tb_mesh_unit_box_normalizer: done, clean");
      else
         $display("tb_mesh_unit_box_normalizer: done, errors");
      $finish;
   end

endmodule
